// ----- rtl/prqd_pkg.sv -----
// Shared types and constants for the priority ready-queue dispatcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package prqd_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PID_BITS_DEF    = 6;
    localparam int PRIO_BITS_DEF   = 8;
    localparam int CTX_BITS        = 16;

    typedef enum logic [1:0] {
        ACT_EXIT  = 2'd0,
        ACT_IDLE  = 2'd1,
        ACT_ADMIT = 2'd2,
        ACT_OTHER = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNKNOWN   = 2'd1,
        ST_NO_ORIGIN = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SRC_CALLER  = 2'd0,
        SRC_PROCESS = 2'd1,
        SRC_ORIGIN  = 2'd2
    } t_src;

    // controller -> datapath
    typedef struct packed {
        logic    latch;
        logic    clear_running;
        logic    set_origin;
        logic    head_rd;
        logic    pop;
        logic    load_running;
        logic    ins_start;
        logic    ins_rd;
        logic    ins_shift;
        logic    ins_place;
        logic    resp_load;
        t_status resp_status;
        t_src    resp_src;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_action action;
        logic    q_empty;
        logic    q_full;
        logic    running_valid;
        logic    origin_valid;
        logic    ins_rem_zero;
        logic    ins_greater;
        logic    out_free;
    } t_stat;

endpackage

// ----- rtl/prqd_controller.sv -----
// Sequencer for the dispatcher: decodes a request and steps the datapath.
// Depends on prqd_pkg for the command/status structs and codes.
`timescale 1ns / 1ps

module prqd_controller
    import prqd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_HEAD_RD,
        S_HEAD_POP,
        S_INS_START,
        S_INS_CHK,
        S_INS_CMP,
        S_RUN,
        S_RESP
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    t_src    r_src, n_src;
    logic    w_ins_done;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_src      = r_src;
        o_cmd      = '0;
        w_ins_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_src    = SRC_CALLER;
                case (i_stat.action)
                    ACT_EXIT: begin
                        o_cmd.clear_running = 1'b1;
                        if (!i_stat.q_empty) begin
                            n_state = S_HEAD_RD;
                        end else if (i_stat.origin_valid) begin
                            n_src   = SRC_ORIGIN;
                            n_state = S_RESP;
                        end else begin
                            n_status = ST_NO_ORIGIN;
                            n_state  = S_RESP;
                        end
                    end
                    ACT_IDLE: begin
                        o_cmd.set_origin = 1'b1;
                        if (!i_stat.q_empty) begin
                            n_state = S_HEAD_RD;
                        end else begin
                            if (!i_stat.running_valid) begin
                                n_src = SRC_ORIGIN;
                            end
                            n_state = S_RESP;
                        end
                    end
                    ACT_ADMIT: begin
                        if (i_stat.q_full) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_INS_START;
                        end
                    end
                    default: begin
                        n_status = ST_UNKNOWN;
                        n_state  = S_RESP;
                    end
                endcase
            end
            S_HEAD_RD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = S_HEAD_POP;
            end
            S_HEAD_POP: begin
                o_cmd.pop = 1'b1;
                // yield puts the preempted process back in line
                if (i_stat.action == ACT_IDLE && i_stat.running_valid) begin
                    n_state = S_INS_START;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_INS_START: begin
                o_cmd.ins_start = 1'b1;
                n_state         = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (i_stat.ins_rem_zero) begin
                    o_cmd.ins_place = 1'b1;
                    w_ins_done      = 1'b1;
                end else begin
                    o_cmd.ins_rd = 1'b1;
                    n_state      = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.ins_greater) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state         = S_INS_CHK;
                end else begin
                    o_cmd.ins_place = 1'b1;
                    w_ins_done      = 1'b1;
                end
            end
            S_RUN: begin
                o_cmd.load_running = 1'b1;
                n_src              = SRC_PROCESS;
                n_state            = S_RESP;
            end
            S_RESP: begin
                o_cmd.resp_status = r_status;
                o_cmd.resp_src    = r_src;
                if (i_stat.out_free) begin
                    o_cmd.resp_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_ins_done) begin
            n_state = (i_stat.action == ACT_ADMIT) ? S_RESP : S_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_src    <= SRC_CALLER;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_src    <= n_src;
        end
    end

endmodule

// ----- rtl/prqd_datapath.sv -----
// Datapath: ready-queue ring memory, running/origin registers, insert walker,
// and the result register. Depends on prqd_pkg.
`timescale 1ns / 1ps

module prqd_datapath
    import prqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = PID_BITS_DEF,
    parameter int PRIO_BITS   = PRIO_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [1:0]           i_action,
    input  logic [CTX_BITS-1:0]  i_caller_context,
    input  logic [PID_BITS-1:0]  i_process_id,
    input  logic [PRIO_BITS-1:0] i_process_priority,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [1:0]           o_status,
    output logic [1:0]           o_resume_source,
    output logic [CTX_BITS-1:0]  o_resume_id
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = IW + 1;
    localparam int WW = PID_BITS + PRIO_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] WRAP     = SW'(QUEUE_DEPTH);

    // ring of {prio, pid}, head at r_head, sorted from head
    logic [WW-1:0] r_mem [QUEUE_DEPTH];
    logic [WW-1:0] r_rdata;

    logic [IW-1:0]        r_head;
    logic [CW-1:0]        r_count;
    t_action              r_action;
    logic [CTX_BITS-1:0]  r_caller;
    logic [PID_BITS-1:0]  r_pid_in;
    logic [PRIO_BITS-1:0] r_prio_in;
    logic                 r_run_valid;
    logic [PID_BITS-1:0]  r_run_pid;
    logic [PRIO_BITS-1:0] r_run_prio;
    logic                 r_origin_valid;
    logic [CTX_BITS-1:0]  r_origin_handle;
    logic [PID_BITS-1:0]  r_pop_pid;
    logic [PRIO_BITS-1:0] r_pop_prio;
    logic [IW-1:0]        r_ins_j;
    logic [CW-1:0]        r_ins_rem;
    logic [WW-1:0]        r_ins_word;
    logic                 r_out_valid;
    t_status              r_out_status;
    t_src                 r_out_src;
    logic [CTX_BITS-1:0]  r_out_id;

    logic [SW-1:0]        w_tail_sum;
    logic [IW-1:0]        w_tail;
    logic [IW-1:0]        w_prev;
    logic [IW-1:0]        w_rd_addr;
    logic [WW-1:0]        w_wr_data;
    logic                 w_wr_en;
    logic [CTX_BITS-1:0]  w_resp_id;

    assign w_tail_sum = SW'(r_head) + SW'(r_count);
    assign w_tail     = (w_tail_sum >= WRAP) ? IW'(w_tail_sum - WRAP) : w_tail_sum[IW-1:0];
    assign w_prev     = (r_ins_j == '0) ? LAST_IDX : r_ins_j - 1'b1;
    assign w_rd_addr  = i_cmd.head_rd ? r_head : w_prev;
    assign w_wr_en    = i_cmd.ins_place || i_cmd.ins_shift;
    assign w_wr_data  = i_cmd.ins_place ? r_ins_word : r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_ins_j] <= w_wr_data;
        end
        if (i_cmd.head_rd || i_cmd.ins_rd) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        w_resp_id = r_caller;
        case (i_cmd.resp_src)
            SRC_PROCESS: begin
                w_resp_id                 = '0;
                w_resp_id[PID_BITS-1:0]   = r_run_pid;
            end
            SRC_ORIGIN: w_resp_id = r_origin_handle;
            default:    w_resp_id = r_caller;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action  <= t_action'(i_action);
            r_caller  <= i_caller_context;
            r_pid_in  <= i_process_id;
            r_prio_in <= i_process_priority;
        end
        if (i_cmd.pop) begin
            r_pop_pid  <= r_rdata[PID_BITS-1:0];
            r_pop_prio <= r_rdata[WW-1:PID_BITS];
        end
        if (i_cmd.ins_start) begin
            r_ins_j   <= w_tail;
            r_ins_rem <= r_count;
            r_ins_word <= (r_action == ACT_ADMIT) ? {r_prio_in, r_pid_in}
                                                  : {r_run_prio, r_run_pid};
        end else if (i_cmd.ins_shift) begin
            r_ins_j   <= w_prev;
            r_ins_rem <= r_ins_rem - 1'b1;
        end
        if (i_cmd.resp_load) begin
            r_out_status <= i_cmd.resp_status;
            r_out_src    <= i_cmd.resp_src;
            r_out_id     <= w_resp_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head          <= '0;
            r_count         <= '0;
            r_run_valid     <= 1'b0;
            r_run_pid       <= '0;
            r_run_prio      <= '0;
            r_origin_valid  <= 1'b0;
            r_origin_handle <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cmd.pop) begin
                r_head  <= (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end else if (i_cmd.ins_place) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.clear_running) begin
                r_run_valid <= 1'b0;
                r_run_pid   <= '0;
                r_run_prio  <= '0;
            end else if (i_cmd.load_running) begin
                r_run_valid <= 1'b1;
                r_run_pid   <= r_pop_pid;
                r_run_prio  <= r_pop_prio;
            end
            if (i_cmd.set_origin && !r_origin_valid) begin
                r_origin_valid  <= 1'b1;
                r_origin_handle <= r_caller;
            end else if (i_cmd.resp_load && i_cmd.resp_src == SRC_ORIGIN) begin
                r_origin_valid  <= 1'b0;
                r_origin_handle <= '0;
            end
            if (i_cmd.resp_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.action        = r_action;
    assign o_stat.q_empty       = (r_count == '0);
    assign o_stat.q_full        = (r_count >= FULL_CNT);
    assign o_stat.running_valid = r_run_valid;
    assign o_stat.origin_valid  = r_origin_valid;
    assign o_stat.ins_rem_zero  = (r_ins_rem == '0);
    assign o_stat.ins_greater   = (r_rdata[WW-1:PID_BITS] > r_ins_word[WW-1:PID_BITS]);
    assign o_stat.out_free      = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_resume_source = r_out_src;
    assign o_resume_id     = r_out_id;

endmodule

// ----- rtl/priority_ready_queue_dispatcher.sv -----
// Top level of the priority ready-queue dispatcher.
// Depends on prqd_pkg, prqd_controller and prqd_datapath.
`timescale 1ns / 1ps

// One request is taken at a time and answered with exactly one result. An exit
// back to the origin context, an exit without one, a yield with an empty queue
// and unknown or rejected requests go from decode straight to the result; an
// exit or a yield that dispatches without preempting reads the head, pops it and
// loads the running process. Admit and a yield that preempts a running process
// insert into the ready queue, which is a ring in a single-port memory kept
// sorted from the head; the insert walks back from the tail and moves each less
// urgent entry one slot, with a registered read and then a compare and write for
// each moved entry. The result sits in an output register; the next request is
// taken in the cycle after it has been loaded, so a result that waits holds off
// the next request. No clearing pass runs after reset.

module priority_ready_queue_dispatcher
    import prqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = PID_BITS_DEF,
    parameter int PRIO_BITS   = PRIO_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_action,
    input  logic [CTX_BITS-1:0]  i_caller_context,
    input  logic [PID_BITS-1:0]  i_process_id,
    input  logic [PRIO_BITS-1:0] i_process_priority,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [1:0]           o_resume_source,
    output logic [CTX_BITS-1:0]  o_resume_id
);

    t_cmd  w_cmd;
    t_stat w_stat;

    prqd_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    prqd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_BITS    (PID_BITS),
        .PRIO_BITS   (PRIO_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_action           (i_action),
        .i_caller_context   (i_caller_context),
        .i_process_id       (i_process_id),
        .i_process_priority (i_process_priority),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_status           (o_status),
        .o_resume_source    (o_resume_source),
        .o_resume_id        (o_resume_id)
    );

endmodule

// ----- rtl/prqd_checker.sv -----
// Port-level checks for the dispatcher, bound to the top level.
// Depends on prqd_pkg and priority_ready_queue_dispatcher.
`timescale 1ns / 1ps

module prqd_checker
    import prqd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [1:0]          o_status,
    input logic [1:0]          o_resume_source,
    input logic [CTX_BITS-1:0] o_resume_id
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_resume_source) && $stable(o_resume_id))
        else $error("result changed while stalled");

    // one request in flight: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again before request finished");

    a_src_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_resume_source == SRC_CALLER || o_resume_source == SRC_PROCESS
            || o_resume_source == SRC_ORIGIN)
        else $error("bad resume source");

    // every error answer resumes the caller
    a_err_caller: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_resume_source == SRC_CALLER)
        else $error("error result with non-caller source");

endmodule

bind priority_ready_queue_dispatcher prqd_checker u_prqd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_resume_source (o_resume_source),
    .o_resume_id     (o_resume_id)
);

// ----- tb/tb.sv -----
// Self-checking testbench for priority_ready_queue_dispatcher.
// Depends on prqd_pkg and the RTL of the block; predicts each answer from its own
// copy of the ready queue, running process and saved origin context.
`timescale 1ns / 1ps

module tb;
    import prqd_pkg::*;

    localparam int QDEPTH       = QUEUE_DEPTH_DEF;
    localparam int PIDW         = PID_BITS_DEF;
    localparam int PRIOW        = PRIO_BITS_DEF;
    localparam int RANDOM_ITEMS = 1225;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * QDEPTH + 20;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        t_action             action;
        logic [CTX_BITS-1:0] caller;
        logic [PIDW-1:0]     pid;
        logic [PRIOW-1:0]    prio;
    } t_request;

    typedef struct packed {
        t_status             status;
        t_src                src;
        logic [CTX_BITS-1:0] id;
    } t_answer;

    typedef struct packed {
        logic [PIDW-1:0]  pid;
        logic [PRIOW-1:0] prio;
    } t_ready_entry;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          action   = '0;
    logic [CTX_BITS-1:0] caller   = '0;
    logic [PIDW-1:0]     pid      = '0;
    logic [PRIOW-1:0]    prio     = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          status;
    logic [1:0]          resume_source;
    logic [CTX_BITS-1:0] resume_id;

    // predictor state
    t_ready_entry        ready_q[$];
    bit                  run_valid;
    logic [PIDW-1:0]     run_pid;
    logic [PRIOW-1:0]    run_prio;
    bit                  origin_valid;
    logic [CTX_BITS-1:0] origin_handle;

    t_request request_backlog[$];
    t_answer  answers_due[$];
    t_request cur_req;
    int       send_wait;
    int       recv_wait;
    bit       send_burst;
    bit       recv_burst;
    int       fault_count;
    int       quiet_cycles;

    priority_ready_queue_dispatcher i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_action           (action),
        .i_caller_context   (caller),
        .i_process_id       (pid),
        .i_process_priority (prio),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_status           (status),
        .o_resume_source    (resume_source),
        .o_resume_id        (resume_id)
    );

    always #5 clk = ~clk;

    // new entry goes behind every entry of equal or more urgent priority
    function automatic void insert_ready(logic [PIDW-1:0] p, logic [PRIOW-1:0] r);
        int pos;
        t_ready_entry e;
        pos = 0;
        e.pid = p;
        e.prio = r;
        while (pos < ready_q.size() && ready_q[pos].prio <= r) pos++;
        ready_q.insert(pos, e);
    endfunction

    function automatic t_answer take_origin();
        t_answer ans;
        ans.status = ST_OK;
        ans.src = SRC_ORIGIN;
        ans.id = origin_handle;
        origin_valid = 1'b0;
        origin_handle = '0;
        run_valid = 1'b0;
        return ans;
    endfunction

    function automatic t_answer predict_dispatch(t_request req);
        t_answer ans;
        t_ready_entry head;
        ans.status = ST_OK;
        ans.src = SRC_CALLER;
        ans.id = req.caller;
        case (req.action)
            ACT_IDLE: begin
                if (!origin_valid) begin
                    origin_valid = 1'b1;
                    origin_handle = req.caller;
                end
                if (ready_q.size() > 0) begin
                    head = ready_q.pop_front();
                    if (run_valid) insert_ready(run_pid, run_prio);
                    run_valid = 1'b1;
                    run_pid = head.pid;
                    run_prio = head.prio;
                    ans.src = SRC_PROCESS;
                    ans.id = CTX_BITS'(head.pid);
                end else if (!run_valid) begin
                    ans = take_origin();
                end
            end
            ACT_EXIT: begin
                run_valid = 1'b0;
                run_pid = '0;
                run_prio = '0;
                if (ready_q.size() > 0) begin
                    head = ready_q.pop_front();
                    run_valid = 1'b1;
                    run_pid = head.pid;
                    run_prio = head.prio;
                    ans.src = SRC_PROCESS;
                    ans.id = CTX_BITS'(head.pid);
                end else if (origin_valid) begin
                    ans = take_origin();
                end else begin
                    ans.status = ST_NO_ORIGIN;
                end
            end
            ACT_ADMIT: begin
                if (ready_q.size() >= QDEPTH) ans.status = ST_FULL;
                else insert_ready(req.pid, req.prio);
            end
            default: ans.status = ST_UNKNOWN;
        endcase
        return ans;
    endfunction

    // roughly one item in forty flips between random waits and back-to-back
    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 40) == 0) burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 6));
    endfunction

    task automatic queue_request(t_action a, logic [CTX_BITS-1:0] c, logic [PIDW-1:0] p,
                                 logic [PRIOW-1:0] r);
        t_request req;
        req.action = a;
        req.caller = c;
        req.pid = p;
        req.prio = r;
        request_backlog.push_back(req);
    endtask

    // request driver
    always @(posedge clk) begin
        bit offer;
        offer = in_valid;
        if (!rst_n) begin
            offer = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                answers_due.push_back(predict_dispatch(cur_req));
                offer = 1'b0;
                send_wait = draw_wait(send_burst);
            end
            if (!offer) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (request_backlog.size() > 0) begin
                    cur_req = request_backlog.pop_front();
                    offer = 1'b1;
                    action <= cur_req.action;
                    caller <= cur_req.caller;
                    pid <= cur_req.pid;
                    prio <= cur_req.prio;
                end
            end
        end
        in_valid <= offer;
    end

    // answer monitor
    always @(posedge clk) begin
        t_answer got;
        t_answer want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got.status = t_status'(status);
                got.src = t_src'(resume_source);
                got.id = resume_id;
                if (answers_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("unexpected answer: status %0d source %0d id %0d",
                                 got.status, got.src, got.id);
                end else begin
                    want = answers_due.pop_front();
                    if (got != want) begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display({"answer mismatch: status %0d/%0d source %0d/%0d ",
                                      "id %0d/%0d (expected/actual)"},
                                     want.status, got.status, want.src, got.src,
                                     want.id, got.id);
                    end
                end
                recv_wait = draw_wait(recv_burst);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any transfer on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("priority_ready_queue_dispatcher verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_mix            mix;
        int              mix_left;
        int unsigned     roll;
        int unsigned     admit_lim;
        int unsigned     idle_lim;
        int unsigned     exit_lim;
        t_action         a;
        logic [CTX_BITS-1:0] c;
        logic [PRIOW-1:0]    r;

        // directed: exit with nothing to return to, unknown code, idle back to origin
        queue_request(ACT_EXIT, 16'hFFFF, '0, '0);
        queue_request(ACT_OTHER, 16'h0000, '1, '1);
        queue_request(ACT_IDLE, 16'hA5A5, '0, '0);
        // fill the ready queue with extremes and equal priorities, then overflow it
        queue_request(ACT_ADMIT, 16'h1234, PIDW'(63), PRIOW'(255));
        queue_request(ACT_ADMIT, 16'h5A5A, PIDW'(0), PRIOW'(0));
        for (int k = 2; k < QDEPTH; k++)
            queue_request(ACT_ADMIT, CTX_BITS'(k * 4099), PIDW'(k * 5),
                          PRIOW'((k % 3) * 100));
        queue_request(ACT_ADMIT, 16'hBEEF, PIDW'(21), PRIOW'(1));
        // dispatch, then preempt the running process back into the queue
        queue_request(ACT_IDLE, 16'h0F0F, '0, '0);
        queue_request(ACT_IDLE, 16'hF0F0, '0, '0);
        queue_request(ACT_EXIT, 16'h00FF, '0, '0);
        queue_request(ACT_EXIT, 16'hFF00, '0, '0);

        // random: phases biased toward filling, draining or an even mix
        mix = MIX_EVEN;
        mix_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mix_left == 0) begin
                mix = t_mix'($urandom_range(0, 2));
                mix_left = $urandom_range(20, 80);
            end
            mix_left--;
            case (mix)
                MIX_FILL:  begin admit_lim = 60; idle_lim = 85; exit_lim = 95; end
                MIX_DRAIN: begin admit_lim = 15; idle_lim = 40; exit_lim = 95; end
                default:   begin admit_lim = 35; idle_lim = 65; exit_lim = 95; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < admit_lim) a = ACT_ADMIT;
            else if (roll < idle_lim) a = ACT_IDLE;
            else if (roll < exit_lim) a = ACT_EXIT;
            else a = ACT_OTHER;

            case ($urandom_range(0, 9))
                0:       c = '0;
                1:       c = '1;
                default: c = CTX_BITS'($urandom_range(0, 65535));
            endcase
            // narrow priorities often so equal-priority ordering gets exercised
            case ($urandom_range(0, 4))
                0, 1:    r = PRIOW'($urandom_range(0, 255));
                2, 3:    r = PRIOW'($urandom_range(0, 3));
                default: r = $urandom_range(0, 1) ? '1 : '0;
            endcase
            queue_request(a, c, PIDW'($urandom_range(0, 63)), r);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (request_backlog.size() != 0 || in_valid || answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && answers_due.size() == 0) begin
            $display("priority_ready_queue_dispatcher verification clean");
        end else begin
            $display("priority_ready_queue_dispatcher verification failed");
        end
        $finish;
    end

endmodule

// ----- priority_ready_queue_dispatcher.f -----
rtl/prqd_pkg.sv
rtl/prqd_controller.sv
rtl/prqd_datapath.sv
rtl/priority_ready_queue_dispatcher.sv
rtl/prqd_checker.sv
tb/tb.sv
